[sv/hsedp_pkg.sv]
// constants for the hub status endpoint descriptor parser
// standalone package, no dependencies

package hsedp_pkg;

  // largest descriptor set the parser walks
  localparam logic [7:0] MaxSetBytes      = 8'd255;
  // smallest legal total length of a set
  localparam logic [7:0] MinTotalLength   = 8'd9;
  // smallest length of a standard descriptor header
  localparam logic [7:0] MinHeaderLength  = 8'd2;
  // descriptor lengths needed to trust interface and endpoint fields
  localparam logic [7:0] MinIfLength      = 8'd9;
  localparam logic [7:0] MinEpLength      = 8'd7;

  // descriptor type codes
  localparam logic [7:0] DescTypeConfig   = 8'h02;
  localparam logic [7:0] DescTypeIf       = 8'h04;
  localparam logic [7:0] DescTypeEp       = 8'h05;
  // interface class code of a hub
  localparam logic [7:0] HubClassCode     = 8'h09;
  // interrupt transfer type in bmAttributes
  localparam logic [1:0] XferInterrupt    = 2'b11;

  // byte positions inside the set
  localparam logic [7:0] PosTotalLow      = 8'd2;
  localparam logic [7:0] PosTotalHigh     = 8'd3;
  localparam logic [7:0] PosLast          = 8'hFF;

  // byte offsets inside one descriptor
  localparam logic [7:0] OffLength        = 8'd0;
  localparam logic [7:0] OffType          = 8'd1;
  localparam logic [7:0] OffEpAddr        = 8'd2;
  localparam logic [7:0] OffEpAttr        = 8'd3;
  localparam logic [7:0] OffEpSizeLow     = 8'd4;
  localparam logic [7:0] OffEpSizeHigh    = 8'd5;
  localparam logic [7:0] OffIfClass       = 8'd5;

  // reset value of the status byte count register
  localparam logic [3:0] StatusBytesReset = 4'd1;

  // result outcome codes
  localparam logic OutcomeBound    = 1'b0;
  localparam logic OutcomeRejected = 1'b1;

endpackage

[sv/hub_status_endpoint_descriptor_parser.sv]
// hub status endpoint descriptor parser, top level
// depends on hsedp_pkg
//
//  port group       | direction | handshake                  | payload
//  -----------------+-----------+----------------------------+----------------------------
//  input bytes      | in        | in_valid_i / in_ready_o    | data_byte_i, first_byte_i
//  results          | out       | out_valid_o / out_ready_i  | outcome_o, endpoint_number_o,
//                   |           |                            | packet_size_o
//  config register  | in        | status_bytes_we_i          | status_bytes_i
//
// one byte per cycle: a transaction loads the input register, the byte is parsed by
// combinational logic while it sits in the input register and any result is written to
// the result register on an edge where the result side can advance.
// the input register stalls only while it holds a byte, a result waits and out_ready_i
// is low. reset is asynchronous, active low, and leaves the parser idle until a byte
// with first_byte_i set arrives; status_bytes resets to 1.

module hub_status_endpoint_descriptor_parser #(
  parameter logic [7:0] MaxSetBytes = hsedp_pkg::MaxSetBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input byte channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  // configuration
  input  logic       status_bytes_we_i,
  input  logic [3:0] status_bytes_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       outcome_o,
  output logic [3:0] endpoint_number_o,
  output logic [7:0] packet_size_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_first_q;

  // result register
  logic       out_valid_q;
  logic       outcome_q;
  logic [3:0] ep_num_q;
  logic [7:0] max_pkt_q;

  // config register
  logic [3:0] status_bytes_q;

  // parse state
  logic [7:0] byte_pos_q,  byte_pos_d;
  logic [7:0] total_q,     total_d;
  logic [7:0] hdr_pos_q,   hdr_pos_d;
  logic [7:0] desc_len_q,  desc_len_d;
  logic [7:0] desc_type_q, desc_type_d;
  logic       in_hub_q,    in_hub_d;
  logic [7:0] ep_addr_q,   ep_addr_d;
  logic       ep_cand_q,   ep_cand_d;
  logic [7:0] size_low_q,  size_low_d;
  logic       finished_q,  finished_d;

  // parse step outputs
  logic       advance;
  logic       decide;
  logic       reject;
  logic [3:0] res_ep_num;
  logic [7:0] res_max_pkt;

  // state seen by the current byte, after a restart on first_byte
  logic [7:0] cur_pos, cur_total, cur_hdr, cur_len, cur_type, cur_addr, cur_size_low;
  logic       cur_hub, cur_cand, cur_fin;
  logic [7:0] offset;
  logic [7:0] len_eff;
  logic [8:0] next_hdr;
  logic [8:0] hdr_plus_len;
  logic [8:0] hdr_plus_data;

  // handshake
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  assign out_valid_o       = out_valid_q;
  assign outcome_o         = outcome_q;
  assign endpoint_number_o = ep_num_q;
  assign packet_size_o     = max_pkt_q;

  // restart view of the state
  always_comb begin
    if (in_first_q) begin
      cur_pos      = '0;
      cur_total    = '0;
      cur_hdr      = '0;
      cur_len      = '0;
      cur_type     = '0;
      cur_hub      = 1'b0;
      cur_addr     = '0;
      cur_cand     = 1'b0;
      cur_size_low = '0;
      cur_fin      = 1'b0;
    end else begin
      cur_pos      = byte_pos_q;
      cur_total    = total_q;
      cur_hdr      = hdr_pos_q;
      cur_len      = desc_len_q;
      cur_type     = desc_type_q;
      cur_hub      = in_hub_q;
      cur_addr     = ep_addr_q;
      cur_cand     = ep_cand_q;
      cur_size_low = size_low_q;
      cur_fin      = finished_q;
    end
  end

  assign offset        = cur_pos - cur_hdr;
  assign hdr_plus_len  = {1'b0, cur_hdr} + {1'b0, cur_len};
  assign hdr_plus_data = {1'b0, cur_hdr} + {1'b0, in_data_q};

  // parse one byte
  always_comb begin
    byte_pos_d  = cur_pos;
    total_d     = cur_total;
    hdr_pos_d   = cur_hdr;
    desc_len_d  = cur_len;
    desc_type_d = cur_type;
    in_hub_d    = cur_hub;
    ep_addr_d   = cur_addr;
    ep_cand_d   = cur_cand;
    size_low_d  = cur_size_low;
    finished_d  = cur_fin;
    decide      = 1'b0;
    reject      = 1'b1;
    res_ep_num  = '0;
    res_max_pkt = '0;
    len_eff     = cur_len;
    next_hdr    = '0;

    if (!cur_fin) begin
      // total length bytes
      if (cur_pos == hsedp_pkg::PosTotalLow) begin
        total_d = in_data_q;
      end
      if (cur_pos == hsedp_pkg::PosTotalHigh) begin
        if (in_data_q != 8'd0 || cur_total < hsedp_pkg::MinTotalLength ||
            {1'b0, cur_total} > {1'b0, MaxSetBytes}) begin
          decide = 1'b1;
        end
      end

      // header length checks
      if (offset == hsedp_pkg::OffLength) begin
        desc_len_d = in_data_q;
        len_eff    = in_data_q;
        if (in_data_q < hsedp_pkg::MinHeaderLength) begin
          decide = 1'b1;
        end
        if (cur_pos >= hsedp_pkg::PosTotalHigh && hdr_plus_data > {1'b0, total_d}) begin
          decide = 1'b1;
        end
      end else if (cur_pos == hsedp_pkg::PosTotalHigh &&
                   hdr_plus_len > {1'b0, cur_total}) begin
        decide = 1'b1;
      end

      // descriptor body
      if (offset == hsedp_pkg::OffType) begin
        desc_type_d = in_data_q;
        ep_cand_d   = 1'b0;
        if (in_data_q == hsedp_pkg::DescTypeIf) begin
          in_hub_d = 1'b0;
        end
      end else if (offset > hsedp_pkg::OffType) begin
        if (cur_type == hsedp_pkg::DescTypeIf) begin
          if (offset == hsedp_pkg::OffIfClass && cur_len >= hsedp_pkg::MinIfLength) begin
            in_hub_d = (in_data_q == hsedp_pkg::HubClassCode);
          end
        end else if (cur_type == hsedp_pkg::DescTypeEp) begin
          if (offset == hsedp_pkg::OffEpAddr) begin
            ep_addr_d = in_data_q;
          end else if (offset == hsedp_pkg::OffEpAttr) begin
            ep_cand_d = cur_hub && cur_len >= hsedp_pkg::MinEpLength && cur_addr[7] &&
                        in_data_q[1:0] == hsedp_pkg::XferInterrupt;
          end else if (offset == hsedp_pkg::OffEpSizeLow) begin
            size_low_d = in_data_q;
          end else if (offset == hsedp_pkg::OffEpSizeHigh && cur_cand && !decide) begin
            // bound endpoint decides the set either way
            decide = 1'b1;
            if (cur_addr[3:0] != 4'd0 && in_data_q[2:0] == 3'd0 &&
                cur_size_low >= {4'd0, status_bytes_q}) begin
              reject      = 1'b0;
              res_ep_num  = cur_addr[3:0];
              res_max_pkt = cur_size_low;
            end
          end
        end
      end

      // end of descriptor, step to next header
      if ({1'b0, offset} + 9'd1 == {1'b0, len_eff}) begin
        next_hdr = {1'b0, cur_hdr} + {1'b0, len_eff};
        if (cur_pos >= hsedp_pkg::PosTotalHigh &&
            {1'b0, next_hdr} + 10'd2 > {2'd0, total_d}) begin
          decide = 1'b1;
        end
        hdr_pos_d = next_hdr[7:0];
      end

      // set too long
      if (cur_pos == hsedp_pkg::PosLast) begin
        decide = 1'b1;
      end
      byte_pos_d = cur_pos + 8'd1;
      if (decide) begin
        finished_d = 1'b1;
      end
    end
  end

  // control and parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      status_bytes_q <= hsedp_pkg::StatusBytesReset;
      byte_pos_q     <= '0;
      total_q        <= '0;
      hdr_pos_q      <= '0;
      desc_len_q     <= '0;
      desc_type_q    <= '0;
      in_hub_q       <= 1'b0;
      ep_addr_q      <= '0;
      ep_cand_q      <= 1'b0;
      size_low_q     <= '0;
      finished_q     <= 1'b1;
    end else begin
      if (status_bytes_we_i) begin
        status_bytes_q <= status_bytes_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && decide;
      end
      if (in_valid_q && advance) begin
        byte_pos_q  <= byte_pos_d;
        total_q     <= total_d;
        hdr_pos_q   <= hdr_pos_d;
        desc_len_q  <= desc_len_d;
        desc_type_q <= desc_type_d;
        in_hub_q    <= in_hub_d;
        ep_addr_q   <= ep_addr_d;
        ep_cand_q   <= ep_cand_d;
        size_low_q  <= size_low_d;
        finished_q  <= finished_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q  <= data_byte_i;
      in_first_q <= first_byte_i;
    end
    if (in_valid_q && advance && decide) begin
      outcome_q <= reject ? hsedp_pkg::OutcomeRejected : hsedp_pkg::OutcomeBound;
      ep_num_q  <= res_ep_num;
      max_pkt_q <= res_max_pkt;
    end
  end

endmodule

[sv/hsedp_checker.sv]
// port-level checks for the hub status endpoint descriptor parser
// bound to hub_status_endpoint_descriptor_parser; no package needed

module hsedp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       outcome_o,
  input logic [3:0] endpoint_number_o,
  input logic [7:0] packet_size_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(outcome_o) &&
      $stable(endpoint_number_o) && $stable(packet_size_o))
    else $error("stalled result changed");

  // a rejected set carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o |-> endpoint_number_o == 4'd0 && packet_size_o == 8'd0)
    else $error("rejected result with nonzero fields");

  // a bound endpoint never has number zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !outcome_o |-> endpoint_number_o != 4'd0)
    else $error("bound endpoint number is zero");

  // a fresh result comes from a byte transaction through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a byte transaction two cycles earlier");

endmodule

bind hub_status_endpoint_descriptor_parser hsedp_checker u_hsedp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .outcome_o         (outcome_o),
  .endpoint_number_o (endpoint_number_o),
  .packet_size_o     (packet_size_o)
);

[sim/parse_result_checker.sv]
`timescale 1ns / 1ps
// result checker for the hub status endpoint descriptor parser: watches both channels
// and the status_bytes register, predicts each result and compares it; depends on hsedp_pkg

module parse_result_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       status_bytes_we_i,
  input  logic [3:0] status_bytes_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       outcome_i,
  input  logic [3:0] endpoint_number_i,
  input  logic [7:0] packet_size_i,
  output int         fail_count_o,
  output int         results_due_o,
  output int         result_count_o,
  output int         bound_count_o
);

  typedef struct packed {
    logic       outcome;
    logic [3:0] ep_num;
    logic [7:0] max_pkt;
  } bind_result_t;

  // parser state as the predictor tracks it
  logic [3:0] min_status;
  logic [7:0] pos;
  logic [7:0] total_len;
  logic [7:0] hdr_pos;
  logic [7:0] desc_len;
  logic [7:0] desc_type;
  logic       in_hub_if;
  logic [7:0] ep_addr;
  logic       ep_cand;
  logic [7:0] size_low;
  logic       set_done;

  bind_result_t pending_results[$];
  bind_result_t observed;
  bind_result_t predicted;
  bind_result_t fresh;

  function automatic void clear_parse();
    pos       = '0;
    total_len = '0;
    hdr_pos   = '0;
    desc_len  = '0;
    desc_type = '0;
    in_hub_if = 1'b0;
    ep_addr   = '0;
    ep_cand   = 1'b0;
    size_low  = '0;
  endfunction

  // ends the set and forms its one result
  function automatic bit close_set(input bit bound, input logic [3:0] ep,
                                   input logic [7:0] mp, output bind_result_t res);
    set_done    = 1'b1;
    res.outcome = bound ? hsedp_pkg::OutcomeBound : hsedp_pkg::OutcomeRejected;
    res.ep_num  = bound ? ep : 4'd0;
    res.max_pkt = bound ? mp : 8'd0;
    return 1'b1;
  endfunction

  // one byte through the parse, returns 1 when it decides the set
  function automatic bit step_parser(input logic [7:0] data, input logic first,
                                     output bind_result_t res);
    int unsigned p, h, off, next, size;
    res = '0;
    if (first) begin
      clear_parse();
      set_done = 1'b0;
    end
    if (set_done) begin
      return 1'b0;
    end
    p   = pos;
    h   = hdr_pos;
    off = p - h;

    // total length arrives in bytes 2 and 3
    if (p == hsedp_pkg::PosTotalLow) begin
      total_len = data;
    end
    if (p == hsedp_pkg::PosTotalHigh && (data != 8'd0 ||
        total_len < hsedp_pkg::MinTotalLength || total_len > hsedp_pkg::MaxSetBytes)) begin
      return close_set(1'b0, 4'd0, 8'd0, res);
    end

    // header length, with the overrun check held back until total is known
    if (off == hsedp_pkg::OffLength) begin
      desc_len = data;
      if (data < hsedp_pkg::MinHeaderLength) begin
        return close_set(1'b0, 4'd0, 8'd0, res);
      end
      if (p >= hsedp_pkg::PosTotalHigh && h + data > total_len) begin
        return close_set(1'b0, 4'd0, 8'd0, res);
      end
    end else if (p == hsedp_pkg::PosTotalHigh && h + desc_len > total_len) begin
      return close_set(1'b0, 4'd0, 8'd0, res);
    end

    // descriptor body
    if (off == hsedp_pkg::OffType) begin
      desc_type = data;
      ep_cand   = 1'b0;
      if (data == hsedp_pkg::DescTypeIf) begin
        in_hub_if = 1'b0;
      end
    end else if (off >= hsedp_pkg::OffEpAddr) begin
      if (desc_type == hsedp_pkg::DescTypeIf) begin
        if (off == hsedp_pkg::OffIfClass && desc_len >= hsedp_pkg::MinIfLength) begin
          in_hub_if = (data == hsedp_pkg::HubClassCode);
        end
      end else if (desc_type == hsedp_pkg::DescTypeEp) begin
        if (off == hsedp_pkg::OffEpAddr) begin
          ep_addr = data;
        end else if (off == hsedp_pkg::OffEpAttr) begin
          ep_cand = in_hub_if && desc_len >= hsedp_pkg::MinEpLength && ep_addr[7] &&
                    data[1:0] == hsedp_pkg::XferInterrupt;
        end else if (off == hsedp_pkg::OffEpSizeLow) begin
          size_low = data;
        end else if (off == hsedp_pkg::OffEpSizeHigh && ep_cand) begin
          size = {data[2:0], size_low};
          if (ep_addr[3:0] == 4'd0 || size < min_status || size > 255) begin
            return close_set(1'b0, 4'd0, 8'd0, res);
          end
          return close_set(1'b1, ep_addr[3:0], 8'(size), res);
        end
      end
    end

    // end of descriptor: another header needs two more bytes of total
    if (off + 1 == desc_len) begin
      next = h + desc_len;
      if (p >= hsedp_pkg::PosTotalHigh && next + 2 > total_len) begin
        return close_set(1'b0, 4'd0, 8'd0, res);
      end
      hdr_pos = 8'(next);
    end

    if (pos == hsedp_pkg::PosLast) begin
      return close_set(1'b0, 4'd0, 8'd0, res);
    end
    pos = pos + 8'd1;
    return 1'b0;
  endfunction

  // results first, since a result never comes from the byte of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      set_done       = 1'b1;
      min_status     = hsedp_pkg::StatusBytesReset;
      pending_results.delete();
      fail_count_o   = 0;
      results_due_o  = 0;
      result_count_o = 0;
      bound_count_o  = 0;
    end else begin
      if (status_bytes_we_i) begin
        min_status = status_bytes_i;
      end

      // compare result transaction with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        observed = {outcome_i, endpoint_number_i, packet_size_i};
        if (pending_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with nothing expected: outcome %0d endpoint %0d packet %0d",
                   $time, observed.outcome, observed.ep_num, observed.max_pkt);
        end else begin
          predicted = pending_results.pop_front();
          if (observed.outcome !== predicted.outcome) begin
            fail_count_o++;
            $display("%0t: outcome mismatch, expected %0d, actual %0d",
                     $time, predicted.outcome, observed.outcome);
          end
          if (observed.ep_num !== predicted.ep_num) begin
            fail_count_o++;
            $display("%0t: endpoint_number mismatch, expected %0d, actual %0d",
                     $time, predicted.ep_num, observed.ep_num);
          end
          if (observed.max_pkt !== predicted.max_pkt) begin
            fail_count_o++;
            $display("%0t: packet_size mismatch, expected %0d, actual %0d",
                     $time, predicted.max_pkt, observed.max_pkt);
          end
          result_count_o++;
          if (predicted.outcome == hsedp_pkg::OutcomeBound) begin
            bound_count_o++;
          end
        end
      end

      // predict from the byte transaction
      if (in_valid_i && in_ready_i) begin
        if (step_parser(data_byte_i, first_byte_i, fresh)) begin
          pending_results.push_back(fresh);
        end
      end
      results_due_o = pending_results.size();
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench top: streams directed and random descriptor sets into the parser, steps
// status_bytes through settings from 1 to 8 and stalls the result side; depends on hsedp_pkg,
// hub_status_endpoint_descriptor_parser and parse_result_checker

module testbench;

  localparam int DrainCycles = 4;
  localparam int HoldCycles  = 500;
  localparam int StallLimit  = 4000;
  localparam int PhaseBytes  = 210;
  localparam int PhaseSets   = 3;

  typedef enum int {KindConfig, KindInterface, KindEndpoint, KindOther} desc_kind_e;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       status_we;
  logic [3:0] status_val;
  logic       out_valid;
  logic       out_ready;
  logic       outcome;
  logic [3:0] ep_num;
  logic [7:0] max_pkt;

  int fail_count;
  int results_due;
  int result_count;
  int bound_count;

  int         bytes_sent;
  int         sets_sent;
  int         burst_left;
  int         gap;
  int         stall_cycles;
  bit         in_random;
  bit         hold_done;
  logic [3:0] cur_status;
  logic [7:0] set_bytes[$];
  int         hdr_starts[$];

  hub_status_endpoint_descriptor_parser dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .data_byte_i       (data_byte),
    .first_byte_i      (first_byte),
    .status_bytes_we_i (status_we),
    .status_bytes_i    (status_val),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .outcome_o         (outcome),
    .endpoint_number_o (ep_num),
    .packet_size_o     (max_pkt)
  );

  parse_result_checker u_result_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .data_byte_i       (data_byte),
    .first_byte_i      (first_byte),
    .status_bytes_we_i (status_we),
    .status_bytes_i    (status_val),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .outcome_i         (outcome),
    .endpoint_number_i (ep_num),
    .packet_size_i     (max_pkt),
    .fail_count_o      (fail_count),
    .results_due_o     (results_due),
    .result_count_o    (result_count),
    .bound_count_o     (bound_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // byte transaction, sent in bursts with random gaps
  task automatic push_byte(input logic [7:0] value, input logic first);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    data_byte  <= value;
    first_byte <= first;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // the first count bytes of set_bytes, first_byte on byte zero
  task automatic send_bytes(input int count);
    if (count > 0) begin
      sets_sent++;
    end
    for (int k = 0; k < count; k++) begin
      push_byte(set_bytes[k], k == 0);
    end
  endtask

  // idle the input and wait out every expected result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_status(input logic [3:0] value);
    status_we  <= 1'b1;
    status_val <= value;
    cur_status = value;
    @(posedge clk);
    status_we <= 1'b0;
  endtask

  // append one descriptor of the given kind and length, random filler elsewhere
  task automatic add_descriptor(input desc_kind_e kind, input int len);
    logic [7:0]  body [256];
    logic [15:0] size;
    int          pick;
    hdr_starts.push_back(set_bytes.size());
    foreach (body[k]) body[k] = 8'($urandom_range(0, 255));
    body[0] = 8'(len);
    case (kind)
      KindConfig: begin
        body[1] = hsedp_pkg::DescTypeConfig;
      end
      KindInterface: begin
        body[1] = hsedp_pkg::DescTypeIf;
        if ($urandom_range(0, 3) != 0) begin
          body[hsedp_pkg::OffIfClass] = hsedp_pkg::HubClassCode;
        end
      end
      KindEndpoint: begin
        body[1] = hsedp_pkg::DescTypeEp;
        body[hsedp_pkg::OffEpAddr][7] = ($urandom_range(0, 6) != 0);
        if ($urandom_range(0, 9) == 0) begin
          body[hsedp_pkg::OffEpAddr][3:0] = 4'd0;
        end else begin
          body[hsedp_pkg::OffEpAddr][3:0] = 4'($urandom_range(1, 15));
        end
        if ($urandom_range(0, 6) != 0) begin
          body[hsedp_pkg::OffEpAttr][1:0] = hsedp_pkg::XferInterrupt;
        end
        // packet size: legal, around either bound, or anything
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          size = 16'($urandom_range(cur_status, 255));
        end else if (pick < 6) begin
          size = 16'(cur_status + $urandom_range(0, 2) - 1);
        end else if (pick < 8) begin
          size = 16'($urandom_range(254, 257));
        end else begin
          size = 16'($urandom_range(0, 16'hFFFF));
        end
        if (pick < 8 && $urandom_range(0, 1) == 1) begin
          size[15:11] = 5'($urandom_range(0, 31));
        end
        body[hsedp_pkg::OffEpSizeLow]  = size[7:0];
        body[hsedp_pkg::OffEpSizeHigh] = size[15:8];
      end
      default: ;
    endcase
    for (int k = 0; k < len; k++) begin
      set_bytes.push_back(body[k]);
    end
  endtask

  // mostly the nominal length, sometimes longer, sometimes too short
  task automatic pick_len(input int nominal, input int longer_lo, input int longer_hi,
                          output int len);
    int r;
    r = $urandom_range(0, 19);
    if (r < 18) begin
      len = nominal;
    end else if (r == 18) begin
      len = $urandom_range(longer_lo, longer_hi);
    end else begin
      len = $urandom_range(2, nominal - 1);
    end
  endtask

  // a well-formed set: optional config header, interfaces followed by endpoints
  task automatic build_set();
    int         room;
    int         count;
    int         len;
    int         left;
    desc_kind_e kind;
    desc_kind_e prev;
    set_bytes.delete();
    hdr_starts.delete();
    room = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 255) : $urandom_range(20, 72);
    prev = KindOther;
    if ($urandom_range(0, 3) != 0) begin
      add_descriptor(KindConfig, 9);
    end
    count = $urandom_range(1, 5);
    repeat (count) begin
      if (prev == KindInterface && $urandom_range(0, 9) < 7) begin
        kind = KindEndpoint;
      end else begin
        case ($urandom_range(0, 3))
          0, 1:    kind = KindInterface;
          2:       kind = KindEndpoint;
          default: kind = KindOther;
        endcase
      end
      case (kind)
        KindInterface: begin
          pick_len(9, 10, 12, len);
        end
        KindEndpoint: begin
          pick_len(7, 8, 9, len);
        end
        default: begin
          len = $urandom_range(2, 12);
        end
      endcase
      if (set_bytes.size() + len <= room) begin
        add_descriptor(kind, len);
        prev = kind;
      end
    end
    // long sets are padded out to their size with other descriptors
    if (room > 150) begin
      left = room - set_bytes.size();
      while (left >= 2) begin
        len = (left <= 40) ? left : $urandom_range(2, 40);
        if (left - len == 1) begin
          len--;
        end
        add_descriptor(KindOther, len);
        left -= len;
      end
    end
    if (set_bytes.size() >= 4) begin
      set_bytes[2] = 8'(set_bytes.size());
      set_bytes[3] = 8'h00;
    end
  endtask

  // random set, sometimes damaged, cut short or surrounded by noise
  task automatic send_random_set();
    int send_count;
    int at;
    build_set();
    send_count = set_bytes.size();
    case ($urandom_range(0, 15))
      0: begin
        if (send_count > 1) begin
          send_count = $urandom_range(1, send_count - 1);
        end
      end
      1: begin
        set_bytes[$urandom_range(0, send_count - 1)] = 8'($urandom_range(0, 255));
      end
      2: begin
        if (send_count >= 4) begin
          if ($urandom_range(0, 1) == 1) begin
            set_bytes[3] = 8'($urandom_range(1, 255));
          end else begin
            set_bytes[2] = 8'($urandom_range(0, 255));
          end
        end
      end
      3: begin
        at = hdr_starts[$urandom_range(0, hdr_starts.size() - 1)];
        if ($urandom_range(0, 1) == 1) begin
          set_bytes[at] = 8'($urandom_range(0, 1));
        end else begin
          set_bytes[at] = 8'($urandom_range(2, 255));
        end
      end
      4: begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      5: begin
        set_bytes.delete();
        send_count = $urandom_range(1, 16);
        repeat (send_count) set_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    send_bytes(send_count);
  endtask

  // receiver stall patterns, with one long hold-off during random traffic
  initial begin : result_sink
    int mode;
    int span;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 200);
      repeat (span) begin
        @(posedge clk);
        if (in_random && bytes_sent >= 400 && !hold_done) begin
          out_ready <= 1'b0;
          repeat (HoldCycles) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles, %0d results still expected",
               $time, StallLimit, results_due);
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [3:0] settings [4];
    int         phase_bytes;
    int         phase_results;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    data_byte  = 8'h00;
    first_byte = 1'b0;
    status_we  = 1'b0;
    status_val = 4'd0;
    cur_status = hsedp_pkg::StatusBytesReset;
    bytes_sent = 0;
    sets_sent  = 0;
    burst_left = 0;
    in_random  = 1'b0;
    hold_done  = 1'b0;
    settings   = '{4'd8, 4'd1, 4'($urandom_range(2, 7)), 4'($urandom_range(1, 8))};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle byte, short header, bad total, late overrun, bind at the extremes
    push_byte(8'hA5, 1'b0);
    set_bytes = '{8'h01};
    send_bytes(set_bytes.size());
    set_bytes = '{8'h09, hsedp_pkg::DescTypeConfig, 8'h14, 8'h01};
    send_bytes(set_bytes.size());
    set_bytes = '{8'h14, hsedp_pkg::DescTypeIf, 8'h0C, 8'h00};
    send_bytes(set_bytes.size());
    set_bytes = '{8'h09, hsedp_pkg::DescTypeIf, 8'h10, 8'h00, 8'h01, hsedp_pkg::HubClassCode,
                  8'h00, 8'h00, 8'h00,
                  8'h07, hsedp_pkg::DescTypeEp, 8'h8F, 8'h03, 8'hFF, 8'h00, 8'hFF};
    send_bytes(set_bytes.size());
    push_byte(8'h5A, 1'b0);
    drain();

    // random phases, one status_bytes setting each
    foreach (settings[ph]) begin
      write_status(settings[ph]);
      in_random     = 1'b1;
      phase_bytes   = bytes_sent + PhaseBytes;
      phase_results = result_count + PhaseSets;
      while (bytes_sent < phase_bytes || result_count < phase_results) begin
        send_random_set();
      end
      in_random = 1'b0;
      drain();
    end

    $display("summary: %0d bytes in %0d sets, %0d results checked, %0d bound",
             bytes_sent, sets_sent, result_count, bound_count);
    $display("summary: status_bytes %0d, %0d, %0d, %0d; receiver hold-off of %0d cycles %0s",
             settings[0], settings[1], settings[2], settings[3], HoldCycles,
             hold_done ? "done" : "missed");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
